[design/dtwc_pkg.sv]
// Package for the delay-threshold congestion window block.
// Holds the shared arithmetic unit's types, register indexes and reset constants.
// Depends on nothing.
package dtwc_pkg;

  // Width of the shared add/subtract unit: one bit above the 32-bit window.
  localparam int unsigned ALU_W = 33;

  // Width of the window state and of the reciprocal.
  localparam int unsigned WIN_W = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_RTT_THRESHOLD  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_WINDOW = 1'd1;

  // Register reset values.
  localparam logic [31:0] RESET_RTT_THRESHOLD  = 32'd500;
  localparam logic [15:0] RESET_INITIAL_WINDOW = 16'd50;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Result of the shared unit: carry out is "no wrap" on a subtraction.
  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] value;
  } alu_res_t;

endpackage

[design/dtwc_alu.sv]
// Shared add/subtract unit of the delay-threshold congestion window block.
// Depends on dtwc_pkg for the operation code and result types.
module dtwc_alu (
  input  dtwc_pkg::alu_op_e               op_i,
  input  logic [dtwc_pkg::ALU_W-1:0]      a_i,
  input  logic [dtwc_pkg::ALU_W-1:0]      b_i,
  output dtwc_pkg::alu_res_t              res_o
);

  logic [dtwc_pkg::ALU_W-1:0] b_sel;
  logic                       carry_in;
  logic [dtwc_pkg::ALU_W:0]   sum;

  // A subtraction is an addition of the inverted operand plus one.
  always_comb begin
    b_sel    = (op_i == dtwc_pkg::ALU_SUB) ? ~b_i : b_i;
    carry_in = (op_i == dtwc_pkg::ALU_SUB);
    sum      = {1'b0, a_i} + {1'b0, b_sel} + {{dtwc_pkg::ALU_W{1'b0}}, carry_in};
  end

  assign res_o.carry = sum[dtwc_pkg::ALU_W];
  assign res_o.value = sum[dtwc_pkg::ALU_W-1:0];

endmodule

[design/delay_threshold_window_control.sv]
// Top level of the delay-threshold congestion window block.
// Depends on dtwc_pkg and on dtwc_alu, the shared add/subtract unit.
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser: action; tdata: send_time, ack_time
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: window
//   cfg       in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// An acknowledgment runs through the division, the update and the output load before the
// next request is accepted: the reciprocal comes from a restoring divider that
// produces one quotient bit a cycle on the shared unit, then one update state and one
// state to load the output register. A timeout skips the division.
// Reset loads the threshold and the initial window and empties the output register.
// A result waiting in the output register does not stop the next request being
// accepted; only a second finished result waits for the first to be taken.
module delay_threshold_window_control #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] send_time, [63:32] ack_time
  input  logic [0:0]  s_axis_tuser,   // [0] action: 0 acknowledgment, 1 timeout

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] window

  input  logic                               cfg_we_i,
  input  logic [dtwc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  // Quotient of 2^(2*FRACTION_BITS) over the window has this many bits.
  localparam int unsigned QW = 2 * FRACTION_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

  // The round-trip time is worked out at least as wide as the threshold.
  localparam int unsigned DW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [DW-1:0] TIME_MASK = {DW{1'b1}} >> (DW - TIME_BITS);

  localparam logic [31:0] ONE_FX       = 32'd1 << FRACTION_BITS;
  localparam logic [31:0] RESET_WINDOW =
    32'(dtwc_pkg::RESET_INITIAL_WINDOW) << FRACTION_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   window_q, window_d;
  logic [31:0]   thr_q, thr_d;
  logic          m_valid_q, m_valid_d;
  logic [15:0]   m_data_q, m_data_d;

  // Working registers of one request; they need no reset.
  logic          action_q;
  logic [DW-1:0] rtt_q;
  logic          lt_q;
  logic [31:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;

  logic                  accept;
  logic [DW-1:0]         rtt_d;
  logic                  gt_one;
  logic [QW+31:0]        quo_ext;
  logic [31:0]           recip;
  logic [32:0]           rem_shift;
  logic [47:0]           int_part;
  logic [15:0]           init_win;
  logic [FRACTION_BITS+47:0] init_ext;
  logic [31:0]           init_fx;

  dtwc_pkg::alu_op_e                alu_op;
  logic [dtwc_pkg::ALU_W-1:0]       alu_a, alu_b;
  dtwc_pkg::alu_res_t               alu_res;

  dtwc_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The round-trip time wraps at the width of the timestamps.
  assign rtt_d = (DW'(s_axis_tdata[63:32]) - DW'(s_axis_tdata[31:0])) & TIME_MASK;

  assign gt_one = (window_q > ONE_FX);

  // The reciprocal saturates when the quotient needs more than 32 bits.
  assign quo_ext = (QW + 32)'(quo_q);
  assign recip   = (|quo_ext[QW+31:32]) ? '1 : quo_ext[31:0];

  // The dividend is a single one at its top bit, so only the first step shifts in a one.
  assign rem_shift = {rem_q, (cnt_q == '0)};

  // Integer part of the window; it is saturated to the 16-bit output when emitted.
  assign int_part = 48'(window_q) >> FRACTION_BITS;

  // Initial window: zero is taken as one, and a value too wide for 32 bits saturates.
  assign init_win = (cfg_data_i[15:0] == '0) ? 16'd1 : cfg_data_i[15:0];
  assign init_ext = (FRACTION_BITS + 48)'(init_win) << FRACTION_BITS;
  assign init_fx  = (|init_ext[FRACTION_BITS+47:32]) ? '1 : init_ext[31:0];

  // Operand selection for the shared unit: division steps, then growth or shrinking.
  always_comb begin
    alu_op = dtwc_pkg::ALU_SUB;
    alu_a  = {1'b0, window_q};
    alu_b  = {1'b0, recip};
    if (state_q == ST_DIV) begin
      alu_a = rem_shift;
      alu_b = {1'b0, window_q};
    end else if (lt_q) begin
      alu_op = dtwc_pkg::ALU_ADD;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    window_d  = window_q;
    thr_d     = thr_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = s_axis_tuser[0] ? ST_UPDATE : ST_DIV;
        end
      end
      ST_DIV: begin
        // A step that fits leaves the difference and sets the quotient bit.
        if (alu_res.carry) begin
          rem_d = alu_res.value[31:0];
        end else begin
          rem_d = rem_shift[31:0];
        end
        quo_d = {quo_q[QW-2:0], alu_res.carry};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (action_q) begin
          if (gt_one) begin
            window_d = window_q >> 1;
          end
        end else if (lt_q) begin
          window_d = alu_res.value[32] ? '1 : alu_res.value[31:0];
        end else if (gt_one) begin
          window_d = alu_res.value[31:0];
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = (|int_part[47:16]) ? 16'hFFFF : int_part[15:0];
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Configuration must be written only while the block is idle; the block does not enforce this.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dtwc_pkg::REG_RTT_THRESHOLD:  thr_d    = cfg_data_i;
        dtwc_pkg::REG_INITIAL_WINDOW: window_d = init_fx;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      window_q  <= RESET_WINDOW;
      thr_q     <= dtwc_pkg::RESET_RTT_THRESHOLD;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      window_q  <= window_d;
      thr_q     <= thr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    m_data_q <= m_data_d;
    if (accept) begin
      action_q <= s_axis_tuser[0];
      rtt_q    <= rtt_d;
    end
    // The comparison settles during the division, well before the update uses it.
    if (state_q == ST_DIV) begin
      lt_q <= (rtt_q < DW'(thr_q));
    end
  end

  // The window can never reach zero, so the reciprocal is always a true quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni) window_q != '0)
    else $error("congestion window reached zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == LAST_STEP) |=> state_q == ST_UPDATE)
    else $error("division did not hand over to the update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request accepted while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!m_valid_q || m_axis_tready)) |=>
      (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished result not loaded into the output register");

endmodule

[tb/dtwc_tb_pkg.sv]
// Scoreboard for the delay-threshold congestion window testbench.
// Predicts the window after each request and checks the results in arrival order.
// Depends on dtwc_pkg for the register indexes and reset values.
package dtwc_tb_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [31:0] ONE_FX    = 32'd1 << FRAC_BITS;
  localparam logic [31:0] WIN_SAT   = 32'hFFFF_FFFF;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_TIMEOUT = 1'b1
  } req_kind_e;

  class window_scoreboard;
    logic [31:0] rtt_threshold;
    logic [15:0] initial_window;
    logic [31:0] cwnd;
    logic [15:0] window_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      rtt_threshold  = dtwc_pkg::RESET_RTT_THRESHOLD;
      initial_window = dtwc_pkg::RESET_INITIAL_WINDOW;
      load_window();
    endfunction

    function void load_window();
      logic [63:0] wide;
      wide = 64'(initial_window) << FRAC_BITS;
      cwnd = (wide > 64'(WIN_SAT)) ? WIN_SAT : wide[31:0];
    endfunction

    function void write_register(logic [dtwc_pkg::CFG_INDEX_W-1:0] index,
                                 logic [31:0] data);
      case (index)
        dtwc_pkg::REG_RTT_THRESHOLD: rtt_threshold = data;
        dtwc_pkg::REG_INITIAL_WINDOW: begin
          // A zero window would never move, so it is taken as one.
          initial_window = (data[15:0] == 16'd0) ? 16'd1 : data[15:0];
          load_window();
        end
        default: ;
      endcase
    endfunction

    function logic [31:0] reciprocal(logic [31:0] w);
      logic [63:0] q;
      if (w == 32'd0) return WIN_SAT;
      q = (64'd1 << (2 * FRAC_BITS)) / 64'(w);
      return (q > 64'(WIN_SAT)) ? WIN_SAT : q[31:0];
    endfunction

    function void note_request(req_kind_e kind, logic [31:0] send_t, logic [31:0] ack_t);
      logic [31:0] rtt;
      logic [31:0] recip;
      logic [32:0] sum;
      logic [31:0] int_part;
      if (kind == KIND_ACK) begin
        rtt   = ack_t - send_t;
        recip = reciprocal(cwnd);
        if (rtt < rtt_threshold) begin
          sum  = {1'b0, cwnd} + {1'b0, recip};
          cwnd = sum[32] ? WIN_SAT : sum[31:0];
        end else if (cwnd > ONE_FX) begin
          cwnd = cwnd - recip;
        end
      end else if (cwnd > ONE_FX) begin
        cwnd = cwnd >> 1;
      end
      int_part = cwnd >> FRAC_BITS;
      window_q.push_back((int_part > 32'hFFFF) ? 16'hFFFF : int_part[15:0]);
    endfunction

    function void check_result(logic [15:0] window);
      logic [15:0] want;
      if (window_q.size() == 0) begin
        $error("window: result with no request outstanding, actual %0d", window);
        mismatches++;
        return;
      end
      want = window_q.pop_front();
      if (window !== want) begin
        $error("window: expected %0d, actual %0d", want, window);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return window_q.size();
    endfunction

    function void report_leftover();
      if (window_q.size() != 0) begin
        $error("window: %0d results never arrived", window_q.size());
        mismatches += window_q.size();
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top for delay_threshold_window_control.
// Drives acknowledgment and timeout requests and register writes, and checks every
// window result against the scoreboard in dtwc_tb_pkg; depends on dtwc_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD       = 8;
  localparam int unsigned RESET_CYCLES     = 12;
  // Covers one acknowledgment's division, update and output load, plus a little margin.
  localparam int unsigned DRAIN_CYCLES     = 48;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned PHASE_REQUESTS   = 75;
  // Far above the slowest legal run of about 500 requests.
  localparam int unsigned RUN_LIMIT_NS     = 5_000_000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_pattern_e;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [63:0]                      s_axis_tdata  = '0;
  logic [0:0]                       s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [15:0]                      m_axis_tdata;
  logic                             cfg_we_i      = 1'b0;
  logic [dtwc_pkg::CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [31:0]                      cfg_data_i    = '0;

  dtwc_tb_pkg::window_scoreboard window_sb = new();

  // Long receiver hold-offs: the stimulus raises the request count, the receiver
  // process serves each one by counting the stall down itself.
  int unsigned holds_requested = 0;
  int unsigned holds_taken     = 0;
  int unsigned hold_left       = 0;
  rx_pattern_e rx_pattern      = RX_ALWAYS;
  int unsigned pattern_left    = 0;

  delay_threshold_window_control DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offers one request and returns at the rising edge where it is taken. The valid
  // stays high afterwards so that back-to-back requests keep the bus busy.
  task automatic send_request(dtwc_tb_pkg::req_kind_e kind, logic [31:0] send_t,
                              logic [31:0] ack_t);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ack_t, send_t};
    do @(posedge clk_i); while (!s_axis_tready);
    window_sb.note_request(kind, send_t, ack_t);
  endtask

  // Drops the valid for the given number of cycles (at least one).
  task automatic idle_sender(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Waits until every outstanding window has come back and the block has gone quiet.
  task automatic settle();
    idle_sender(1);
    while (window_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [dtwc_pkg::CFG_INDEX_W-1:0] index, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    window_sb.write_register(index, data);
  endtask

  // Receiver: a stall pattern that changes every so often, and the long hold-offs.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_taken != holds_requested) begin
      m_axis_tready <= 1'b0;
      holds_taken   <= holds_taken + 1;
      hold_left     <= LONG_HOLD_CYCLES;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern   <= rx_pattern_e'($urandom_range(0, 3));
        pattern_left <= $urandom_range(20, 300);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (rx_pattern)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every window taken by the receiver is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      window_sb.check_result(m_axis_tdata);
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] threshold;
    logic [31:0] rtt;
    logic [31:0] send_t;
    logic [32:0] near;
    int unsigned burst_left;
    bit          sender_idles;
    dtwc_tb_pkg::req_kind_e kind;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset values (threshold 500, window 50).
    send_request(dtwc_tb_pkg::KIND_ACK, 32'h0000_0000, 32'h0000_0000);     // zero round trip
    send_request(dtwc_tb_pkg::KIND_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // top timestamps
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd100, 32'd599);       // just below threshold
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd100, 32'd600);       // exactly at threshold
    send_request(dtwc_tb_pkg::KIND_ACK, 32'hFFFF_FF00, 32'h0000_0010);     // wrapped, short
    send_request(dtwc_tb_pkg::KIND_ACK, 32'h0000_0001, 32'h0000_0000);     // wrapped, longest
    // The timestamps of a timeout are ignored.
    send_request(dtwc_tb_pkg::KIND_TIMEOUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(dtwc_tb_pkg::KIND_TIMEOUT, 32'h0000_0000, 32'hFFFF_FFFF);

    // Nothing ever grows, and a zero initial window is taken as one.
    settle();
    write_register(dtwc_pkg::REG_RTT_THRESHOLD, 32'h0000_0000);
    write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'hFFFF_0000);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd7, 32'd7);           // at 1.0: no shrink
    send_request(dtwc_tb_pkg::KIND_TIMEOUT, 32'd0, 32'd0);       // at 1.0: no halving

    // Everything grows except the longest round trip; drive the window below one.
    settle();
    write_register(dtwc_pkg::REG_RTT_THRESHOLD, 32'hFFFF_FFFF);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd5, 32'd5);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd1, 32'd0);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd1, 32'd0);           // now below 1.0
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd1, 32'd0);           // no further shrink
    send_request(dtwc_tb_pkg::KIND_TIMEOUT, 32'd0, 32'd0);       // not halved
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd9, 32'd9);           // grows back

    // Largest initial window: growth near the top of the range, then halving and shrinking.
    settle();
    write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'h0000_FFFF);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd0, 32'd0);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd0, 32'd0);
    send_request(dtwc_tb_pkg::KIND_TIMEOUT, 32'd0, 32'd0);
    send_request(dtwc_tb_pkg::KIND_ACK, 32'd1, 32'd0);

    // Random phases, each with a fresh threshold and initial window. The pause
    // before each phase lets every window come back before the registers change.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       threshold = $urandom_range(1, 2000);
        1:       threshold = 32'h0000_0000;
        2:       threshold = $urandom();
        3:       threshold = 32'hFFFF_FFFF;
        4:       threshold = $urandom_range(0, 2000);
        default: threshold = 32'd1;
      endcase
      write_register(dtwc_pkg::REG_RTT_THRESHOLD, threshold);
      case (phase)
        0:       write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'd1);
        1:       write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'h0000_FFFF);
        2:       write_register(dtwc_pkg::REG_INITIAL_WINDOW, $urandom_range(1, 200));
        3:       write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'd0);
        4:       write_register(dtwc_pkg::REG_INITIAL_WINDOW, $urandom());
        default: write_register(dtwc_pkg::REG_INITIAL_WINDOW, 32'd2);
      endcase

      // Every third phase the sender never idles; in one of them the receiver
      // holds off for a long stretch so the block fills up and stalls its input.
      sender_idles = (phase % 3 != 2);
      if (phase == 2) holds_requested++;
      burst_left = 0;

      for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
        if (phase == 3 && n == PHASE_REQUESTS / 2) begin
          // Sender pauses mid-phase until the block has returned everything.
          idle_sender(1);
          while (window_sb.pending() != 0) @(posedge clk_i);
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (sender_idles) idle_sender($urandom_range(1, 45));
        end
        burst_left--;

        kind   = ($urandom_range(0, 4) == 0) ? dtwc_tb_pkg::KIND_TIMEOUT
                                             : dtwc_tb_pkg::KIND_ACK;
        send_t = $urandom();
        if (kind == dtwc_tb_pkg::KIND_TIMEOUT) begin
          send_request(kind, send_t, $urandom());
        end else begin
          // Round trips cluster around the threshold so both branches are taken.
          case ($urandom_range(0, 9)) inside
            [0:3]: rtt = (threshold == 0) ? 32'd0 : $urandom_range(0, threshold - 1);
            [4:5]: begin
              near = {1'b0, threshold} + 33'($urandom_range(0, 1000));
              rtt  = near[32] ? 32'hFFFF_FFFF : near[31:0];
            end
            [6:7]:   rtt = $urandom_range(threshold, 32'hFFFF_FFFF);
            8:       rtt = threshold;
            default: rtt = $urandom();
          endcase
          send_request(kind, send_t, send_t + rtt);
        end
      end
    end

    idle_sender(1);
    while (window_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    window_sb.report_leftover();
    if (window_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/dtwc_pkg.sv
design/dtwc_alu.sv
design/delay_threshold_window_control.sv
tb/dtwc_tb_pkg.sv
tb/tb_top.sv
